### hdl/htw_pkg.sv
// Shared types and constants of the hierarchical timer wheel.
`timescale 1ns / 1ps
package htw_pkg;

   localparam int ID_W       = 5;
   localparam int LINK_W     = 6;
   localparam int INTERVAL_W = 32;
   localparam int TICK_W     = 48;
   localparam int COUNT_W    = 6;
   localparam int TIMER_SLOTS = 32;

   localparam logic [LINK_W-1:0] EMPTY_LINK = 6'd63;

   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_CANCEL  = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;
   localparam logic [1:0] OP_INVALID = 2'd3;

   typedef enum logic [1:0] {
      KIND_ACCEPTED  = 2'd0,
      KIND_EXPIRED   = 2'd1,
      KIND_REJECTED  = 2'd2,
      KIND_TICK_DONE = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RESULT,
      ST_PSUB,
      ST_PCALC,
      ST_PWRITE,
      ST_CR_FIN,
      ST_CN_READ,
      ST_CN_HEAD,
      ST_CN_WALK,
      ST_CN_FIN,
      ST_T_HEAD,
      ST_T_NEXT,
      ST_T_ENTRY,
      ST_T_EMIT,
      ST_T_ADV,
      ST_C_START,
      ST_C_HEAD,
      ST_C_NEXT,
      ST_C_ENTRY,
      ST_C_END,
      ST_T_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [ID_W-1:0]       timer_id;
      logic [INTERVAL_W-1:0] period_ticks;
      logic                  repeat_req;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [ID_W-1:0]      expired_id;
      logic [COUNT_W-1:0]   active_count;
      logic                 last;
   } rsp_type;

endpackage

### hdl/htw_if.sv
// Request and response channel interfaces of the hierarchical timer wheel.
`timescale 1ns / 1ps
interface htw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [4:0]  timer_id;
   logic [31:0] period_ticks;
   logic        repeat_req;

   modport source (output valid, output opcode, output timer_id, output period_ticks,
                   output repeat_req, input ready);
   modport sink (input valid, input opcode, input timer_id, input period_ticks,
                 input repeat_req, output ready);
endinterface

interface htw_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [4:0] expired_id;
   logic [5:0] active_count;
   logic       last;

   modport source (output valid, output kind, output expired_id, output active_count,
                   output last, input ready);
   modport sink (input valid, input kind, input expired_id, input active_count,
                 input last, output ready);
endinterface

### hdl/htw_core.sv
// Sequencer of the timer wheel with the slot-head memory and the timer memory.
`timescale 1ns / 1ps
module htw_core #(
   parameter int WHEEL_BITS = 8,
   parameter int MAX_TIMERS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  htw_pkg::req_type req,
   input  logic             req_fire,
   output logic             req_ready,
   output htw_pkg::rsp_type res,
   output logic             res_valid,
   input  logic             res_ready
);
   import htw_pkg::*;

   localparam int B           = WHEEL_BITS;
   localparam int SA_W        = WHEEL_BITS + 2;
   localparam int SLOTS_TOTAL = 4 << WHEEL_BITS;
   localparam logic [LINK_W-1:0] ID_LIMIT = LINK_W'(MAX_TIMERS);

   typedef struct packed {
      logic [LINK_W-1:0]     link;
      logic [TICK_W-1:0]     deadline;
      logic [INTERVAL_W-1:0] period;
      logic                  rep;
      logic [SA_W-1:0]       slot;
   } tmr_entry_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   req_type   req_ff, req_in;
   kind_type  kind_ff, kind_in;

   logic [B-1:0]          pos_ff [4];
   logic [B-1:0]          pos_in [4];
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [TIMER_SLOTS-1:0] armed_ff, armed_in;
   logic [ID_W-1:0]       pid_ff, pid_in, prev_ff, prev_in;
   logic [LINK_W-1:0]     cur_ff, cur_in, clink_ff, clink_in;
   logic [TICK_W-1:0]     deadline_ff, deadline_in, r_ff, r_in;
   logic [INTERVAL_W-1:0] period_ff, period_in;
   logic                  rep_ff, rep_in;
   logic [SA_W-1:0]       pidx_ff, pidx_in, clr_ff, clr_in;
   logic [1:0]            cw_ff, cw_in;

   logic [LINK_W-1:0]  slot_mem_ff [SLOTS_TOTAL];
   logic [LINK_W-1:0]  slot_q_ff;
   logic               slot_we;
   logic [SA_W-1:0]    slot_waddr, slot_raddr;
   logic [LINK_W-1:0]  slot_wdata;

   tmr_entry_type      tmr_mem_ff [TIMER_SLOTS];
   tmr_entry_type      tmr_q_ff;
   logic               tmr_we;
   logic [ID_W-1:0]    tmr_waddr, tmr_raddr;
   tmr_entry_type      tmr_wdata;

   logic [1:0]         wsel, pos_idx;
   logic [B-1:0]       qsel, pos_rd, slot_sel;
   logic [TICK_W-1:0]  diff;
   logic               id_ok;

   always_comb begin
      if (r_ff[TICK_W-1:B] == '0) begin
         wsel = 2'd0;
         qsel = r_ff[B-1:0];
      end else if (r_ff[TICK_W-1:2*B] == '0) begin
         wsel = 2'd1;
         qsel = r_ff[2*B-1:B];
      end else if (r_ff[TICK_W-1:3*B] == '0) begin
         wsel = 2'd2;
         qsel = r_ff[3*B-1:2*B];
      end else begin
         wsel = 2'd3;
         qsel = r_ff[4*B-1:3*B];
      end
      pos_idx  = (state_ff == ST_PCALC) ? wsel : cw_ff;
      pos_rd   = pos_ff[pos_idx];
      slot_sel = qsel + pos_rd;
      diff     = deadline_ff - tick_ff;
      id_ok    = {1'b0, req_ff.timer_id} < ID_LIMIT;
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      req_in      = req_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      tick_in     = tick_ff;
      total_in    = total_ff;
      armed_in    = armed_ff;
      pid_in      = pid_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      clink_in    = clink_ff;
      deadline_in = deadline_ff;
      r_in        = r_ff;
      period_in   = period_ff;
      rep_in      = rep_ff;
      pidx_in     = pidx_ff;
      clr_in      = clr_ff;
      cw_in       = cw_ff;
      slot_we     = 1'b0;
      slot_waddr  = pidx_ff;
      slot_wdata  = EMPTY_LINK;
      slot_raddr  = pidx_ff;
      tmr_we      = 1'b0;
      tmr_waddr   = pid_ff;
      tmr_wdata   = tmr_q_ff;
      tmr_raddr   = pid_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      res         = '{kind: kind_ff, expired_id: req_ff.timer_id, active_count: total_ff,
                      last: 1'b1};

      unique case (state_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == {SA_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               req_in   = req;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (req_ff.opcode)
               OP_CREATE: begin
                  if (!id_ok || req_ff.period_ticks == '0 || armed_ff[req_ff.timer_id]) begin
                     kind_in  = KIND_REJECTED;
                     state_in = ST_RESULT;
                  end else begin
                     deadline_in = tick_ff + TICK_W'(req_ff.period_ticks);
                     period_in   = req_ff.period_ticks;
                     rep_in      = req_ff.repeat_req;
                     pid_in      = req_ff.timer_id;
                     ret_in      = ST_CR_FIN;
                     state_in    = ST_PSUB;
                  end
               end
               OP_CANCEL: begin
                  if (!id_ok || !armed_ff[req_ff.timer_id]) begin
                     kind_in  = KIND_REJECTED;
                     state_in = ST_RESULT;
                  end else begin
                     tmr_raddr = req_ff.timer_id;
                     state_in  = ST_CN_READ;
                  end
               end
               OP_TICK: begin
                  slot_raddr = {2'd0, pos_ff[0]};
                  pidx_in    = {2'd0, pos_ff[0]};
                  state_in   = ST_T_HEAD;
               end
               default: begin
                  kind_in  = KIND_REJECTED;
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_PSUB: begin
            r_in     = diff[TICK_W-1] ? '0 : diff;
            state_in = ST_PCALC;
         end
         ST_PCALC: begin
            pidx_in    = {wsel, slot_sel};
            slot_raddr = {wsel, slot_sel};
            state_in   = ST_PWRITE;
         end
         ST_PWRITE: begin
            tmr_we     = 1'b1;
            tmr_waddr  = pid_ff;
            tmr_wdata  = '{link: slot_q_ff, deadline: deadline_ff, period: period_ff,
                           rep: rep_ff, slot: pidx_ff};
            slot_we    = 1'b1;
            slot_waddr = pidx_ff;
            slot_wdata = {1'b0, pid_ff};
            state_in   = ret_ff;
         end
         ST_CR_FIN: begin
            armed_in[pid_ff] = 1'b1;
            total_in         = total_ff + 1'b1;
            kind_in          = KIND_ACCEPTED;
            state_in         = ST_RESULT;
         end
         ST_CN_READ: begin
            clink_in   = tmr_q_ff.link;
            pidx_in    = tmr_q_ff.slot;
            slot_raddr = tmr_q_ff.slot;
            state_in   = ST_CN_HEAD;
         end
         ST_CN_HEAD: begin
            if (slot_q_ff == {1'b0, req_ff.timer_id}) begin
               slot_we    = 1'b1;
               slot_wdata = clink_ff;
               state_in   = ST_CN_FIN;
            end else begin
               prev_in   = slot_q_ff[ID_W-1:0];
               tmr_raddr = slot_q_ff[ID_W-1:0];
               state_in  = ST_CN_WALK;
            end
         end
         ST_CN_WALK: begin
            if (tmr_q_ff.link == {1'b0, req_ff.timer_id}) begin
               tmr_we         = 1'b1;
               tmr_waddr      = prev_ff;
               tmr_wdata      = tmr_q_ff;
               tmr_wdata.link = clink_ff;
               state_in       = ST_CN_FIN;
            end else begin
               prev_in   = tmr_q_ff.link[ID_W-1:0];
               tmr_raddr = tmr_q_ff.link[ID_W-1:0];
            end
         end
         ST_CN_FIN: begin
            armed_in[req_ff.timer_id] = 1'b0;
            if (total_ff != '0) begin
               total_in = total_ff - 1'b1;
            end
            kind_in  = KIND_ACCEPTED;
            state_in = ST_RESULT;
         end
         ST_T_HEAD: begin
            cur_in   = slot_q_ff;
            slot_we  = 1'b1;
            state_in = ST_T_NEXT;
         end
         ST_T_NEXT: begin
            if (cur_ff == EMPTY_LINK) begin
               state_in = ST_T_ADV;
            end else begin
               tmr_raddr = cur_ff[ID_W-1:0];
               pid_in    = cur_ff[ID_W-1:0];
               state_in  = ST_T_ENTRY;
            end
         end
         ST_T_ENTRY: begin
            cur_in      = tmr_q_ff.link;
            deadline_in = tick_ff + TICK_W'(tmr_q_ff.period);
            period_in   = tmr_q_ff.period;
            rep_in      = tmr_q_ff.rep;
            if (tmr_q_ff.rep) begin
               ret_in   = ST_T_EMIT;
               state_in = ST_PSUB;
            end else begin
               armed_in[pid_ff] = 1'b0;
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
               state_in = ST_T_EMIT;
            end
         end
         ST_T_EMIT: begin
            res_valid = 1'b1;
            res = '{kind: KIND_EXPIRED, expired_id: pid_ff, active_count: total_ff,
                    last: 1'b0};
            if (res_ready) begin
               state_in = ST_T_NEXT;
            end
         end
         ST_T_ADV: begin
            tick_in   = tick_ff + 1'b1;
            pos_in[0] = pos_ff[0] + 1'b1;
            if (pos_ff[0] == {B{1'b1}}) begin
               pos_in[1] = pos_ff[1] + 1'b1;
               cw_in     = 2'd1;
               state_in  = ST_C_START;
            end else begin
               state_in = ST_T_DONE;
            end
         end
         ST_C_START: begin
            pidx_in    = {cw_ff, pos_rd};
            slot_raddr = {cw_ff, pos_rd};
            state_in   = ST_C_HEAD;
         end
         ST_C_HEAD: begin
            cur_in   = slot_q_ff;
            slot_we  = 1'b1;
            state_in = ST_C_NEXT;
         end
         ST_C_NEXT: begin
            if (cur_ff == EMPTY_LINK) begin
               state_in = ST_C_END;
            end else begin
               tmr_raddr = cur_ff[ID_W-1:0];
               pid_in    = cur_ff[ID_W-1:0];
               state_in  = ST_C_ENTRY;
            end
         end
         ST_C_ENTRY: begin
            cur_in      = tmr_q_ff.link;
            deadline_in = tmr_q_ff.deadline;
            period_in   = tmr_q_ff.period;
            rep_in      = tmr_q_ff.rep;
            ret_in      = ST_C_NEXT;
            state_in    = ST_PSUB;
         end
         ST_C_END: begin
            if (pos_rd == '0 && cw_ff != 2'd3) begin
               pos_in[cw_ff + 2'd1] = pos_ff[cw_ff + 2'd1] + 1'b1;
               cw_in    = cw_ff + 2'd1;
               state_in = ST_C_START;
            end else begin
               state_in = ST_T_DONE;
            end
         end
         ST_T_DONE: begin
            res_valid = 1'b1;
            res = '{kind: KIND_TICK_DONE, expired_id: '0, active_count: total_ff,
                    last: 1'b1};
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         tick_ff  <= '0;
         total_ff <= '0;
         armed_ff <= '0;
         pos_ff   <= '{default: '0};
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         tick_ff  <= tick_in;
         total_ff <= total_in;
         armed_ff <= armed_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      req_ff      <= req_in;
      kind_ff     <= kind_in;
      pid_ff      <= pid_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      clink_ff    <= clink_in;
      deadline_ff <= deadline_in;
      r_ff        <= r_in;
      period_ff   <= period_in;
      rep_ff      <= rep_in;
      pidx_ff     <= pidx_in;
      cw_ff       <= cw_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem_ff[slot_waddr] <= slot_wdata;
      end
      slot_q_ff <= slot_mem_ff[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (tmr_we) begin
         tmr_mem_ff[tmr_waddr] <= tmr_wdata;
      end
      tmr_q_ff <= tmr_mem_ff[tmr_raddr];
   end

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      $countones(armed_ff) == int'(total_ff))
      else $error("armed timer count disagrees with armed flags");

   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && res.last) |=> state_ff == ST_IDLE)
      else $error("final result transfer did not return to idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PWRITE) |-> armed_ff[pid_ff] || ret_ff == ST_CR_FIN)
      else $error("placing a timer that is not armed");

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !res_valid)
      else $error("request taken while a result is pending");
`endif

endmodule

### hdl/hierarchical_timer_wheel_unit.sv
// Top level of the four-level hierarchical timer wheel with its result register.
//
//   channel | dir | handshake         | payload
//   req_ch  | in  | valid/ready       | opcode, timer_id, period_ticks, repeat_req
//   rsp_ch  | out | valid/ready       | kind, expired_id, active_count, last
//
// One item is worked at a time by a sequencer around two memories with registered reads.
// A cancel walks past every timer ahead of it in its slot. A tick expires or re-arms
// the timers of the current slot and cascades the timers of higher wheels as they roll over.
// After reset all 4 * 2^WHEEL_BITS slot heads are cleared before requests are taken.
// A stalled result sink holds the sequencer only when the result register is full.
`timescale 1ns / 1ps
module hierarchical_timer_wheel_unit #(
   parameter int WHEEL_BITS = 8,
   parameter int MAX_TIMERS = 32
) (
   input  logic       clock,
   input  logic       reset,
   htw_req_if.sink    req_ch,
   htw_rsp_if.source  rsp_ch
);
   import htw_pkg::*;

   req_type req_s;
   rsp_type res_s;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    core_ready, res_valid, buf_free, req_fire;

   assign req_s    = '{opcode: req_ch.opcode, timer_id: req_ch.timer_id,
                       period_ticks: req_ch.period_ticks, repeat_req: req_ch.repeat_req};
   assign req_ch.ready = core_ready;
   assign req_fire = req_ch.valid & core_ready;
   assign buf_free = !rsp_valid_ff || rsp_ch.ready;

   htw_core #(
      .WHEEL_BITS (WHEEL_BITS),
      .MAX_TIMERS (MAX_TIMERS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req       (req_s),
      .req_fire  (req_fire),
      .req_ready (core_ready),
      .res       (res_s),
      .res_valid (res_valid),
      .res_ready (buf_free)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (res_valid && buf_free) begin
         rsp_in       = res_s;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = 2'(rsp_ff.kind);
   assign rsp_ch.expired_id   = rsp_ff.expired_id;
   assign rsp_ch.active_count = rsp_ff.active_count;
   assign rsp_ch.last         = rsp_ff.last;

endmodule
